>>> design/axis_sample_window_average_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the sample window averager
// Shared property forms used by the checker.
// ----------------------------------------------------------------------------
`ifndef AXIS_SAMPLE_WINDOW_AVERAGE_DEFINES_SVH
`define AXIS_SAMPLE_WINDOW_AVERAGE_DEFINES_SVH

// antecedent holds, consequent must hold in the next cycle
`define ASW_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

// antecedent holds, consequent must hold in the same cycle
`define ASW_ASSERT_SAME(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

`endif

>>> design/asw_pkg.sv
// ----------------------------------------------------------------------------
// asw_pkg
// Types, codes and constants shared by the sample window averager.
// ----------------------------------------------------------------------------
package asw_pkg;

   localparam int VALUE_W    = 15;
   localparam int AXIS_W     = 3;
   localparam int SCOUNT_W   = 5;
   localparam int OBITS_W    = 4;
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 5;

   localparam logic [SCOUNT_W-1:0] SCOUNT_RESET = 5'd4;
   localparam logic [OBITS_W-1:0]  OBITS_RESET  = 4'd12;

   typedef enum logic {
      CMD_PUSH  = 1'b0,
      CMD_QUERY = 1'b1
   } cmd_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_SAMPLE_COUNT = 1'b0,
      CSR_OUTPUT_BITS  = 1'b1
   } csr_idx_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SUM,
      ST_DRAIN,
      ST_SCALE,
      ST_DIV,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic busy;
      logic done;
   } div_stat_type;

   // bits to index v entries, never less than one
   function automatic int clog2_min1(input int v);
      int r;
      r = $clog2(v);
      return (r < 1) ? 1 : r;
   endfunction

endpackage

>>> design/asw_history.sv
// ----------------------------------------------------------------------------
// asw_history
// Per-axis sample history in one synchronous RAM, kept as a circular buffer
// per axis with a head pointer and a fill count. Entries past the fill count
// read as zero, which stands in for clearing the RAM at reset.
// ----------------------------------------------------------------------------
module asw_history
   import asw_pkg::*;
#(
   parameter int AXES          = 5,
   parameter int HISTORY_DEPTH = 16,
   parameter int SAMPLE_BITS   = 12
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  push_en,
   input  logic [clog2_min1(AXES)-1:0]           push_axis,
   input  logic [SAMPLE_BITS-1:0]                push_sample,
   input  logic                                  rd_en,
   input  logic [clog2_min1(AXES)-1:0]           rd_axis,
   input  logic [clog2_min1(HISTORY_DEPTH)-1:0]  rd_index,
   output logic [SAMPLE_BITS-1:0]                rd_data
);

   localparam int AX_W      = clog2_min1(AXES);
   localparam int SLOT_W    = clog2_min1(HISTORY_DEPTH);
   localparam int CNT_W     = clog2_min1(HISTORY_DEPTH + 1);
   localparam int MEM_DEPTH = AXES * HISTORY_DEPTH;
   localparam int MEM_AW    = clog2_min1(MEM_DEPTH);

   logic [SAMPLE_BITS-1:0] hist_mem_ff [MEM_DEPTH];
   logic [SAMPLE_BITS-1:0] rd_q_ff;
   logic                   rd_live_ff;
   logic                   rd_live_in;

   logic [SLOT_W-1:0] head_ff [AXES];
   logic [CNT_W-1:0]  fill_ff [AXES];
   logic [SLOT_W-1:0] head_in;
   logic [CNT_W-1:0]  fill_in;

   logic [AX_W-1:0]   ptr_axis;
   logic [SLOT_W-1:0] head_cur;
   logic [CNT_W-1:0]  fill_cur;
   logic [SLOT_W:0]   slot_sum;
   logic [SLOT_W-1:0] rd_slot;
   logic [MEM_AW-1:0] push_addr;
   logic [MEM_AW-1:0] rd_addr;

   // pushes and reads never share a cycle, so one pointer port serves both
   assign ptr_axis = push_en ? push_axis : rd_axis;
   assign head_cur = head_ff[ptr_axis];
   assign fill_cur = fill_ff[ptr_axis];

   always_comb begin
      head_in = (head_cur == '0) ? SLOT_W'(HISTORY_DEPTH - 1) : head_cur - 1'b1;
      fill_in = (fill_cur == CNT_W'(HISTORY_DEPTH)) ? fill_cur : fill_cur + 1'b1;

      slot_sum = (SLOT_W + 1)'(head_cur) + (SLOT_W + 1)'(rd_index);
      if (32'(slot_sum) >= HISTORY_DEPTH) begin
         rd_slot = SLOT_W'(32'(slot_sum) - HISTORY_DEPTH);
      end else begin
         rd_slot = slot_sum[SLOT_W-1:0];
      end

      push_addr  = MEM_AW'(MEM_AW'(push_axis) * MEM_AW'(HISTORY_DEPTH))
                   + MEM_AW'(head_in);
      rd_addr    = MEM_AW'(MEM_AW'(rd_axis) * MEM_AW'(HISTORY_DEPTH))
                   + MEM_AW'(rd_slot);
      rd_live_in = CNT_W'(rd_index) < fill_cur;
   end

   always_ff @(posedge clock) begin
      if (push_en) begin
         hist_mem_ff[push_addr] <= push_sample;
      end
      if (rd_en) begin
         rd_q_ff <= hist_mem_ff[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int a = 0; a < AXES; a++) begin
            head_ff[a] <= '0;
            fill_ff[a] <= '0;
         end
         rd_live_ff <= 1'b0;
      end else begin
         if (push_en) begin
            head_ff[push_axis] <= head_in;
            fill_ff[push_axis] <= fill_in;
         end
         if (rd_en) begin
            rd_live_ff <= rd_live_in;
         end
      end
   end

   // entry never written since reset reads as zero
   assign rd_data = rd_live_ff ? rd_q_ff : '0;

endmodule

>>> design/asw_divider.sv
// ----------------------------------------------------------------------------
// asw_divider
// Serial restoring divider, one quotient bit per cycle. Only the low VALUE_W
// quotient bits are formed; the caller guarantees the quotient fits.
// ----------------------------------------------------------------------------
module asw_divider
   import asw_pkg::*;
#(
   parameter int DIVIDEND_W = 20,
   parameter int DIVISOR_W  = 5
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  logic [DIVIDEND_W-1:0] dividend,
   input  logic [DIVISOR_W-1:0]  divisor,
   output logic [VALUE_W-1:0]    quotient,
   output div_stat_type          stat
);

   localparam int STEP_W = clog2_min1(VALUE_W);

   logic                 busy_ff, busy_in;
   logic [STEP_W-1:0]    step_ff, step_in;
   logic [DIVISOR_W-1:0] rem_ff, rem_in;
   logic [DIVISOR_W-1:0] dvs_ff, dvs_in;
   logic [VALUE_W-1:0]   quo_ff, quo_in;

   logic [DIVISOR_W:0]   trial;
   logic [DIVISOR_W:0]   diff;
   logic                 fits;
   logic                 last_step;

   assign last_step = (step_ff == STEP_W'(VALUE_W - 1));

   always_comb begin
      trial = {rem_ff, quo_ff[VALUE_W-1]};
      diff  = trial - {1'b0, dvs_ff};
      fits  = (trial >= {1'b0, dvs_ff});

      busy_in = busy_ff;
      step_in = step_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      quo_in  = quo_ff;

      if (start) begin
         busy_in = 1'b1;
         step_in = '0;
         rem_in  = DIVISOR_W'(dividend >> VALUE_W);
         quo_in  = dividend[VALUE_W-1:0];
         dvs_in  = divisor;
      end else if (busy_ff) begin
         rem_in  = fits ? diff[DIVISOR_W-1:0] : trial[DIVISOR_W-1:0];
         quo_in  = {quo_ff[VALUE_W-2:0], fits};
         step_in = step_ff + 1'b1;
         if (last_step) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         step_ff <= step_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
      quo_ff <= quo_in;
   end

   assign quotient  = quo_ff;
   assign stat.busy = busy_ff;
   assign stat.done = busy_ff && last_step;

endmodule

>>> design/axis_sample_window_average.sv
// ----------------------------------------------------------------------------
// axis_sample_window_average
// A push transaction (cmd 0) stores a sample at the front of its axis history;
// a push to an axis beyond AXES is dropped. A query transaction (cmd 1)
// reads the newest n = sample_count samples of its axis (zero counts as 1,
// above HISTORY_DEPTH as HISTORY_DEPTH) one per cycle from the history RAM,
// scales the sum to output_bits and divides it by n in a 15-step serial
// divider. With no result stall the result shows and the input opens again
// in the same cycle. A query to an axis beyond AXES skips the history and
// the divider and returns 0. The input side stalls while a query is in work.
// The result sits in an output register, so the next transaction is taken
// while it waits. History is empty after reset through per-axis fill counts;
// no clearing pass runs. Configuration writes are always ready and belong in
// idle periods.
// ----------------------------------------------------------------------------
module axis_sample_window_average
   import asw_pkg::*;
#(
   parameter int AXES          = 5,
   parameter int HISTORY_DEPTH = 16,
   parameter int SAMPLE_BITS   = 12
) (
   input  logic                  clock,
   input  logic                  reset,

   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic                  req_cmd,
   input  logic [AXIS_W-1:0]     req_axis,
   input  logic [SAMPLE_BITS-1:0] req_sample,

   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic [VALUE_W-1:0]    rsp_value,

   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   localparam int AX_W    = clog2_min1(AXES);
   localparam int SLOT_W  = clog2_min1(HISTORY_DEPTH);
   localparam int CNT_W   = clog2_min1(HISTORY_DEPTH + 1);
   localparam int SUM_W   = SAMPLE_BITS + $clog2(HISTORY_DEPTH + 1);
   localparam int LSH_MAX = (SAMPLE_BITS < VALUE_W) ? (VALUE_W - SAMPLE_BITS) : 0;
   localparam int DW_RAW  = SUM_W + LSH_MAX;
   localparam int DW      = (DW_RAW > VALUE_W) ? DW_RAW : (VALUE_W + 1);

   state_type state_ff, state_in;

   logic [SCOUNT_W-1:0] scount_ff, scount_in;
   logic [OBITS_W-1:0]  obits_ff, obits_in;
   logic [CNT_W-1:0]    cnt_ff, cnt_in;
   logic [AX_W-1:0]     ax_ff, ax_in;
   logic                bad_ff, bad_in;
   logic                rd_pend_ff, rd_pend_in;
   logic [SUM_W-1:0]    sum_ff, sum_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [VALUE_W-1:0]  rsp_value_ff, rsp_value_in;

   logic                   req_take;
   logic                   is_query;
   logic                   axis_ok;
   logic                   push_en;
   logic                   rd_en;
   logic                   div_start;
   logic                   out_load;
   logic                   out_free;
   logic [CNT_W-1:0]       n_eff;
   logic [SAMPLE_BITS-1:0] rd_data;
   logic [DW-1:0]          dividend;
   logic [4:0]             lsh;
   logic [4:0]             rsh;
   logic [VALUE_W-1:0]     quotient;
   div_stat_type           div_stat;

   assign req_take = req_valid && !req_stall;
   assign is_query = (req_cmd == CMD_QUERY);
   assign axis_ok  = (32'(req_axis) < AXES);
   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign csr_ready = 1'b1;

   always_comb begin
      if (scount_ff == '0) begin
         n_eff = CNT_W'(1);
      end else if (32'(scount_ff) > HISTORY_DEPTH) begin
         n_eff = CNT_W'(HISTORY_DEPTH);
      end else begin
         n_eff = CNT_W'(scount_ff);
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid && is_query) begin
               state_in = axis_ok ? ST_SUM : ST_DONE;
            end
         end
         ST_SUM: begin
            if (cnt_ff == n_eff - 1'b1) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: state_in = ST_SCALE;
         ST_SCALE: state_in = ST_DIV;
         ST_DIV: begin
            if (div_stat.done) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // state outputs
   always_comb begin
      req_stall = 1'b1;
      rd_en     = 1'b0;
      div_start = 1'b0;
      out_load  = 1'b0;
      unique case (state_ff)
         ST_IDLE:  req_stall = 1'b0;
         ST_SUM:   rd_en     = 1'b1;
         ST_DRAIN: ;
         ST_SCALE: div_start = 1'b1;
         ST_DIV:   ;
         ST_DONE:  out_load  = out_free;
         default:  ;
      endcase
   end

   assign push_en = req_take && !is_query && axis_ok;

   // scale the window sum to the requested resolution
   always_comb begin
      lsh = 5'(obits_ff) - 5'(SAMPLE_BITS);
      rsh = 5'(SAMPLE_BITS) - 5'(obits_ff);
      if (32'(obits_ff) >= SAMPLE_BITS) begin
         dividend = DW'(sum_ff) << lsh;
      end else begin
         dividend = DW'(sum_ff >> rsh);
      end
   end

   always_comb begin
      scount_in    = scount_ff;
      obits_in     = obits_ff;
      cnt_in       = cnt_ff;
      ax_in        = ax_ff;
      bad_in       = bad_ff;
      rd_pend_in   = rd_en;
      sum_in       = sum_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_value_in = rsp_value_ff;

      if (csr_valid && csr_ready) begin
         unique case (csr_idx_type'(csr_index))
            CSR_SAMPLE_COUNT: scount_in = csr_wdata;
            CSR_OUTPUT_BITS:  obits_in  = csr_wdata[OBITS_W-1:0];
            default:          ;
         endcase
      end

      if (rd_pend_ff) begin
         sum_in = sum_ff + SUM_W'(rd_data);
      end
      if (rd_en) begin
         cnt_in = cnt_ff + 1'b1;
      end

      if (req_take && is_query) begin
         cnt_in = '0;
         sum_in = '0;
         ax_in  = AX_W'(req_axis);
         bad_in = !axis_ok;
      end

      // drop the result once taken, then refill from a finished query
      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
      if (out_load) begin
         rsp_valid_in = 1'b1;
         rsp_value_in = bad_ff ? '0 : quotient;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         scount_ff    <= SCOUNT_RESET;
         obits_ff     <= OBITS_RESET;
         rd_pend_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         scount_ff    <= scount_in;
         obits_ff     <= obits_in;
         rd_pend_ff   <= rd_pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff       <= cnt_in;
      ax_ff        <= ax_in;
      bad_ff       <= bad_in;
      sum_ff       <= sum_in;
      rsp_value_ff <= rsp_value_in;
   end

   asw_history #(
      .AXES          (AXES),
      .HISTORY_DEPTH (HISTORY_DEPTH),
      .SAMPLE_BITS   (SAMPLE_BITS)
   ) u_history (
      .clock       (clock),
      .reset       (reset),
      .push_en     (push_en),
      .push_axis   (AX_W'(req_axis)),
      .push_sample (req_sample),
      .rd_en       (rd_en),
      .rd_axis     (ax_ff),
      .rd_index    (cnt_ff[SLOT_W-1:0]),
      .rd_data     (rd_data)
   );

   asw_divider #(
      .DIVIDEND_W (DW),
      .DIVISOR_W  (CNT_W)
   ) u_divider (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (dividend),
      .divisor  (n_eff),
      .quotient (quotient),
      .stat     (div_stat)
   );

   assign rsp_valid = rsp_valid_ff;
   assign rsp_value = rsp_value_ff;

endmodule

>>> design/asw_checker.sv
// ----------------------------------------------------------------------------
// asw_checker
// Port-level checks of the sample window averager, bound to the top level.
// ----------------------------------------------------------------------------
`include "axis_sample_window_average_defines.svh"

module asw_checker
   import asw_pkg::*;
(
   input logic               clock,
   input logic               reset,
   input logic               req_valid,
   input logic               req_stall,
   input logic               req_cmd,
   input logic               rsp_valid,
   input logic               rsp_stall,
   input logic [VALUE_W-1:0] rsp_value
);

   `ASW_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_value), "stalled result changed")

   `ASW_ASSERT_NEXT(a_query_blocks, clock, reset, req_valid && !req_stall && (req_cmd == CMD_QUERY), req_stall, "query transaction did not block the input")

   `ASW_ASSERT_NEXT(a_push_single, clock, reset, req_valid && !req_stall && (req_cmd == CMD_PUSH), !req_stall, "push transaction blocked the input")

   `ASW_ASSERT_SAME(a_rsp_from_query, clock, reset, $rose(rsp_valid), $past(req_stall), "result appeared with no query in work")

endmodule

bind axis_sample_window_average asw_checker u_asw_checker (.*);
